// ===== hdl/c_escape_decoder_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef C_ESCAPE_DECODER_UNIT_DEFINES_SVH
`define C_ESCAPE_DECODER_UNIT_DEFINES_SVH

// implication in the same cycle, quiet while reset is high
`define CED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication in the next cycle, quiet while reset is high
`define CED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication in the next cycle, checked during reset too
`define CED_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ced_pkg.sv =====
// shared types, character codes and helpers of the escape decoder
package ced_pkg;

   localparam int COUNT_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int COUNT_W             = 16;

   // characters
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_7      = 8'h37;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_UA     = 8'h41;
   localparam logic [7:0] CHAR_UF     = 8'h46;
   localparam logic [7:0] CHAR_LA     = 8'h61;
   localparam logic [7:0] CHAR_LB     = 8'h62;
   localparam logic [7:0] CHAR_LF     = 8'h66;
   localparam logic [7:0] CHAR_LN     = 8'h6E;
   localparam logic [7:0] CHAR_LR     = 8'h72;
   localparam logic [7:0] CHAR_LT     = 8'h74;
   localparam logic [7:0] CHAR_LV     = 8'h76;
   localparam logic [7:0] CHAR_LX     = 8'h78;

   // control codes
   localparam logic [7:0] CTL_BEL = 8'd7;
   localparam logic [7:0] CTL_BS  = 8'd8;
   localparam logic [7:0] CTL_FF  = 8'd12;
   localparam logic [7:0] CTL_LF  = 8'd10;
   localparam logic [7:0] CTL_CR  = 8'd13;
   localparam logic [7:0] CTL_HT  = 8'd9;
   localparam logic [7:0] CTL_VT  = 8'd11;
   localparam logic [7:0] CTL_NUL = 8'd0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_word_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               out_last;
      logic [COUNT_W-1:0] decoded_count;
   } rsp_word_type;

   // one or two decoded bytes caused by one input word
   typedef struct packed {
      logic               two;
      logic               last;
      logic [7:0]         byte0;
      logic [COUNT_W-1:0] count0;
      logic [7:0]         byte1;
      logic [COUNT_W-1:0] count1;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c inside {[CHAR_0:CHAR_9]}) begin
         h.value = 4'(c - CHAR_0);
      end else if (c inside {[CHAR_UA:CHAR_UF]}) begin
         h.value = 4'(c - CHAR_UA + 8'd10);
      end else if (c inside {[CHAR_LA:CHAR_LF]}) begin
         h.value = 4'(c - CHAR_LA + 8'd10);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== hdl/ced_front.sv =====
// front end: escape state machine, classifies each word into queue entries
module ced_front import ced_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type req_word,
   output logic         push,
   output entry_type    entry
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BSLASH,
      PH_OCT1,
      PH_OCT2,
      PH_HEX0,
      PH_HEX1
   } phase_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   phase_type             phase_ff, phase_in;
   logic [7:0]            value_ff, value_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [COUNT_BITS-1:0] cnt0, cnt1;
   logic                  emit0, emit1;
   logic [7:0]            byte0, byte1;
   logic [7:0]            b;
   logic                  last;
   logic                  is_oct;
   hex_type               hex;
   logic [7:0]            oct_next, hex_next;

   assign b        = req_word.in_byte;
   assign last     = req_word.in_last;
   assign is_oct   = b inside {[CHAR_0:CHAR_7]};
   assign hex      = hex_digit(b);
   assign oct_next = {value_ff[4:0], b[2:0]};
   assign hex_next = {value_ff[3:0], hex.value};

   // saturating counts for first and second word
   assign cnt0 = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_BITS'(1);
   assign cnt1 = (cnt0 == COUNT_MAX) ? cnt0 : cnt0 + COUNT_BITS'(1);

   always_comb begin
      phase_in = phase_ff;
      value_in = value_ff;
      emit0    = 1'b0;
      emit1    = 1'b0;
      byte0    = b;
      byte1    = b;
      case (phase_ff)
         PH_BSLASH: begin
            phase_in = PH_IDLE;
            emit0    = 1'b1;
            case (b)
               CHAR_LA: byte0 = CTL_BEL;
               CHAR_LB: byte0 = CTL_BS;
               CHAR_LF: byte0 = CTL_FF;
               CHAR_LN: byte0 = CTL_LF;
               CHAR_LR: byte0 = CTL_CR;
               CHAR_LT: byte0 = CTL_HT;
               CHAR_LV: byte0 = CTL_VT;
               CHAR_LX: begin
                  value_in = 8'd0;
                  phase_in = PH_HEX0;
                  emit0    = last;
                  byte0    = CTL_NUL;
               end
               default: begin
                  if (is_oct) begin
                     value_in = {5'd0, b[2:0]};
                     phase_in = PH_OCT1;
                     emit0    = last;
                     byte0    = {5'd0, b[2:0]};
                  end
               end
            endcase
         end
         PH_OCT1, PH_OCT2, PH_HEX0, PH_HEX1: begin
            if ((phase_ff inside {PH_OCT1, PH_OCT2}) ? is_oct : hex.valid) begin
               value_in = (phase_ff inside {PH_OCT1, PH_OCT2}) ? oct_next : hex_next;
               if ((phase_ff == PH_OCT1 || phase_ff == PH_HEX0) && !last) begin
                  phase_in = (phase_ff == PH_OCT1) ? PH_OCT2 : PH_HEX1;
               end else begin
                  phase_in = PH_IDLE;
                  emit0    = 1'b1;
                  byte0    = value_in;
               end
            end else begin
               // flush the open escape, then treat the byte as fresh
               emit0 = 1'b1;
               byte0 = value_ff;
               if (b == CHAR_BSLASH) begin
                  phase_in = PH_BSLASH;
                  emit1    = last;
                  byte1    = CTL_NUL;
               end else begin
                  phase_in = PH_IDLE;
                  emit1    = 1'b1;
               end
            end
         end
         default: begin
            if (b == CHAR_BSLASH) begin
               phase_in = PH_BSLASH;
               emit0    = last;
               byte0    = CTL_NUL;
            end else begin
               phase_in = PH_IDLE;
               emit0    = 1'b1;
            end
         end
      endcase

      count_in = emit1 ? cnt1 : (emit0 ? cnt0 : count_ff);
      if (last) begin
         phase_in = PH_IDLE;
         value_in = 8'd0;
         count_in = '0;
      end
   end

   assign push         = accept && emit0;
   assign entry.two    = emit1;
   assign entry.last   = last;
   assign entry.byte0  = byte0;
   assign entry.count0 = COUNT_W'(cnt0);
   assign entry.byte1  = byte1;
   assign entry.count1 = COUNT_W'(cnt1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         value_ff <= 8'd0;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         value_ff <= value_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/ced_fifo.sv =====
// small entry queue between front and back end
module ced_fifo import ced_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      head_valid,
   output logic      full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   entry_type      mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]    fill_ff, fill_in;
   logic           do_push, do_pop;

   assign full       = (fill_ff == (AW+1)'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      fill_in = fill_ff;
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + (AW+1)'(1);
         2'b01:   fill_in = fill_ff - (AW+1)'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + AW'(1);
         end
      end
   end

endmodule

// ===== hdl/ced_back.sv =====
// back end: splits queue entries into single result words
module ced_back import ced_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head,
   input  logic         head_valid,
   output logic         entry_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);

   logic second_ff;
   logic take;

   assign rsp_empty = !head_valid;
   assign take      = rsp_pop && head_valid;
   assign entry_pop = take && (!head.two || second_ff);

   assign rsp_word.out_byte      = second_ff ? head.byte1 : head.byte0;
   assign rsp_word.decoded_count = second_ff ? head.count1 : head.count0;
   assign rsp_word.out_last      = head.last && (second_ff || !head.two);

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else if (take) begin
         second_ff <= head.two && !second_ff;
      end
   end

endmodule

// ===== hdl/c_escape_decoder_unit.sv =====
// top level of the streaming c escape sequence decoder
//
// c escape decoder: takes an escaped string one nonzero byte per word on the
// req_ side and delivers decoded bytes on the rsp_ side, each with out_last on
// the final decoded byte of the string and a running decoded_count that starts
// at 1 for every string and saturates at 2^COUNT_BITS-1 (low 16 bits shown).
// throughput is one input word per clock while the queue is not full: the
// escape state machine in the front end classifies a word in the cycle it
// is accepted and writes its one or two result bytes as a single entry into
// a QUEUE_DEPTH-entry queue. the back end hands out one result word per
// clock from the queue head while rsp_pop is high, so a word that closes an
// open escape and also produces its own byte gives two result words; the
// queue absorbs these. results are registered in the queue. req_full follows
// the queue fill level only; words that produce no byte (a backslash, an
// unfinished octal or hex escape) take no queue slot.
module c_escape_decoder_unit import ced_pkg::*; #(
   parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // input words
   input  logic         req_push,
   output logic         req_full,
   input  req_word_type req_word,
   // result words
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);

   logic      accept;      // input word taken this cycle
   logic      push;        // front end has an entry for the queue
   entry_type push_entry;
   entry_type head;
   logic      head_valid;
   logic      entry_pop;   // back end is done with the head entry
   logic      q_full;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // escape state machine and count
   ced_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .push     (push),
      .entry    (push_entry)
   );

   // decouples front and back end
   ced_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (entry_pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   // one result word per clock out of the queue while rsp_pop is high
   ced_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .entry_pop  (entry_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== hdl/ced_checker.sv =====
// port level checks of the escape decoder and their bind
`include "c_escape_decoder_unit_defines.svh"

module ced_checker import ced_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_push,
   input logic         req_full,
   input req_word_type req_word,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input rsp_word_type rsp_word
);

   logic rsp_take;

   assign rsp_take = rsp_pop && !rsp_empty;

   `CED_ASSERT_ALWAYS(a_reset_clears, clock, reset, rsp_empty && !req_full, "queue not clear after reset")

   `CED_ASSERT_NEXT(a_stall_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_word), "stalled result word changed")

   `CED_ASSERT_NOW(a_count_steps, clock, reset, $past(rsp_take && !rsp_word.out_last) && !rsp_empty, rsp_word.decoded_count == $past(rsp_word.decoded_count) || rsp_word.decoded_count == COUNT_W'($past(rsp_word.decoded_count) + COUNT_W'(1)), "count did not step by one")

   `CED_ASSERT_NOW(a_count_restarts, clock, reset, $past(rsp_take && rsp_word.out_last) && !rsp_empty, rsp_word.decoded_count == COUNT_W'(1), "new string does not count from one")

   // the final word of a string always decodes to at least one byte
   `CED_ASSERT_NEXT(a_last_gives_word, clock, reset, req_push && !req_full && req_word.in_last, !rsp_empty, "string end produced no word")

endmodule

bind c_escape_decoder_unit ced_checker u_ced_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_word  (req_word),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);
